/* hw/rtl/sitoa_pkg.sv */
// Shared constants, types and command/status structs for the integer to decimal text converter.
package sitoa_pkg;

    // Most digits a 32-bit magnitude can have.
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int unsigned DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 6;

    // ASCII codes, reduced to the six bits that the character port carries.
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 6'd45;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 6'd48;

    // Reciprocal of ten: floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for any 32-bit x.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SHIFT = 35;

    typedef logic [3:0] digit_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new value and clear the digit count
        logic divide;      // peel off one decimal digit, least significant first
        logic emit_sign;   // present the minus sign
        logic emit_digit;  // present the most significant remaining digit
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic neg;         // the captured value is negative
        logic quot_zero;   // the quotient of the current division step is zero
        logic last_digit;  // exactly one digit is left to present
    } status_t;

endpackage

/* hw/rtl/sitoa_dp.sv */
// Datapath: magnitude register, divide-by-ten step, digit buffer and character register.
module sitoa_dp
    import sitoa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [VALUE_W-1:0] value,
    input  cmd_t                      cmd,
    output status_t                   status,
    output logic        [CHAR_W-1:0]  character,
    output logic                      last
);

    logic [VALUE_W-1:0]   mag_reg;
    logic [VALUE_W-1:0]   mag_next;
    logic                 neg_reg;
    logic [DIG_CNT_W-1:0] cnt_reg;
    logic [DIG_CNT_W-1:0] cnt_next;
    digit_t               dig_reg [MAX_DIGITS];
    logic [CHAR_W-1:0]    char_reg;
    logic                 last_reg;

    logic [VALUE_W-1:0]       value_u;
    logic [2*VALUE_W-1:0]     prod;
    logic [VALUE_W-1:0]       quot;
    logic [3:0]               quot10_low;
    digit_t                   rem_digit;
    logic [DIG_IDX_W-1:0]     wr_idx;
    logic [DIG_IDX_W-1:0]     rd_idx;
    logic [DIG_CNT_W-1:0]     cnt_minus1;

    assign value_u = VALUE_W'(value);

    // Multiply by the reciprocal of ten and keep the high bits for the quotient.
    assign prod = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);

    // The remainder is below ten, so its low four bits come from the low bits alone.
    assign quot10_low = {quot[2:0], 1'b0} + {quot[0], 3'b000};
    assign rem_digit  = mag_reg[3:0] - quot10_low;

    assign cnt_minus1 = cnt_reg - DIG_CNT_W'(1);
    assign wr_idx     = cnt_reg[DIG_IDX_W-1:0];
    assign rd_idx     = cnt_minus1[DIG_IDX_W-1:0];

    always_comb
    begin
        mag_next = mag_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            mag_next = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
            cnt_next = '0;
        end
        else if (cmd.divide)
        begin
            mag_next = quot;
            cnt_next = cnt_reg + DIG_CNT_W'(1);
        end
        else if (cmd.emit_digit)
        begin
            cnt_next = cnt_minus1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (cmd.load)
        begin
            neg_reg <= value_u[VALUE_W-1];
        end
        if (cmd.divide)
        begin
            dig_reg[wr_idx] <= rem_digit;
        end
        if (cmd.emit_sign)
        begin
            char_reg <= MINUS_CHAR;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= ZERO_CHAR + CHAR_W'(dig_reg[rd_idx]);
            last_reg <= (cnt_reg == DIG_CNT_W'(1));
        end
    end

    assign status.neg        = neg_reg;
    assign status.quot_zero  = (quot == '0);
    assign status.last_digit = (cnt_reg == DIG_CNT_W'(1));

    assign character = char_reg;
    assign last      = last_reg;

    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> cnt_reg != '0)
        else $error("digit requested from an empty buffer");

    a_divide_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.divide |-> cnt_reg < DIG_CNT_W'(MAX_DIGITS))
        else $error("digit buffer overflow");

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cnt_reg == '0)
        else $error("load did not clear the digit count");

endmodule

/* hw/rtl/sitoa_ctrl.sv */
// Controller: state machine that sequences load, division steps and character output.
module sitoa_ctrl
    import sitoa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    strobe
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       strobe_reg;
    logic       strobe_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.divide = 1'b1;
                if (status.quot_zero)
                begin
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                cmd.emit_sign = 1'b1;
                state_next    = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                cmd.emit_digit = 1'b1;
                if (status.last_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        strobe_next = cmd.emit_sign | cmd.emit_digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;

    a_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == ST_IDLE) |=> state_reg == ST_DIV)
        else $error("accepted request did not start division");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT && status.last_digit) |=> state_reg == ST_IDLE && strobe_reg)
        else $error("final digit did not end the request");

    a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> status.neg)
        else $error("minus sign for a non-negative value");

endmodule

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
//  Channel   Ports                  Handshake
//  --------  ---------------------  -------------------------------------------
//  request   value[31:0] (signed)   taken at a rising edge with start high, busy low
//  result    character[5:0], last   one cycle per character, marked by strobe
//
// While busy, the converter peels off the N decimal digits (N from 1 to 10), then presents
// a minus sign for a negative value and the N digits; a new request is taken only while
// busy is low, so one value is finished before the next one is taken.
// The digit count is set by the divide-by-ten unit, which produces one digit per cycle
// least significant first; the digits then leave most significant first, one per cycle.
// Each character is registered before it appears on the outputs.
// Reset (rst_n low) returns the controller to idle and drops strobe; the digit buffer
// is not cleared. The receiver cannot stall, so characters always leave at full rate.
module signed_int_to_decimal_ascii
    import sitoa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      strobe,
    output logic        [CHAR_W-1:0]  character,
    output logic                      last
);

    cmd_t    cmd;
    status_t status;

    // The controller decides what happens each cycle; the datapath holds the numbers.
    sitoa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    // The datapath divides the magnitude by ten until nothing is left, buffers the
    // remainders, and then reads them back in reverse order as ASCII characters.
    sitoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .character (character),
        .last      (last)
    );

endmodule
